/* rtl/piar_pkg.sv */
// ----------------------------------------------------------------------------
// piar_pkg
// Shared types and constants of the positional insert/remove array: item
// layouts, operation codes and the command that the control broadcasts to the
// row of cells.
// ----------------------------------------------------------------------------
package piar_pkg;

  parameter int MAX_ENTRIES  = 16;
  parameter int DATA_WIDTH   = 8;
  parameter int CAP_AT_RESET = 10;

  parameter int OP_W  = 3;
  parameter int POS_W = 5;
  parameter int VAL_W = 8;
  parameter int CNT_W = 5;

  typedef enum logic [OP_W-1:0] {
    OP_READ    = 3'd0,
    OP_INSERT  = 3'd1,
    OP_APPEND  = 3'd2,
    OP_REMOVE  = 3'd3,
    OP_RESERVE = 3'd4
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] new_value;
    logic [CNT_W-1:0] requested_capacity;
  } in_item_t;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] read_value;
    logic [CNT_W-1:0] entry_count;
    logic [CNT_W-1:0] current_capacity;
  } out_item_t;

  typedef struct packed {
    logic write;
    logic shift_up;
    logic shift_down;
  } cmd_t;

endpackage

/* rtl/piar_cell.sv */
// ----------------------------------------------------------------------------
// piar_cell
// One entry of the array. Holds its value, loads new data, or takes the value
// of its lower or upper neighbor when the row shifts.
// ----------------------------------------------------------------------------
module piar_cell #(
  parameter int MAX_ENTRIES = piar_pkg::MAX_ENTRIES,
  parameter int DATA_WIDTH  = piar_pkg::DATA_WIDTH,
  parameter int INDEX       = 0
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  piar_pkg::cmd_t                               cmd_i,
  input  logic [(($clog2(MAX_ENTRIES+1) > 6) ?
                 $clog2(MAX_ENTRIES+1) : 6)-1:0]       pos_i,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]             count_i,
  input  logic [DATA_WIDTH-1:0]                        data_i,
  input  logic [DATA_WIDTH-1:0]                        lower_i,
  input  logic [DATA_WIDTH-1:0]                        upper_i,
  output logic [DATA_WIDTH-1:0]                        q_o
);

  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW = (CntW > 6) ? CntW : 6;
  localparam logic [CmpW-1:0] Idx     = CmpW'(INDEX);
  localparam logic [CmpW-1:0] IdxNext = CmpW'(INDEX + 1);

  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [CmpW-1:0]       cnt_x;

  assign cnt_x = CmpW'(count_i);

  always_comb begin
    val_d = val_q;
    if (cmd_i.write && (pos_i == Idx)) begin
      val_d = data_i;
    end else if (cmd_i.shift_up && (Idx > pos_i) && (Idx <= cnt_x)) begin
      val_d = lower_i;
    end else if (cmd_i.shift_down && (Idx >= pos_i) && (IdxNext < cnt_x)) begin
      val_d = upper_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule

/* rtl/piar_ctrl.sv */
// ----------------------------------------------------------------------------
// piar_ctrl
// Decodes each item against the entry count and capacity, drives the cell row
// and holds the registered result.
// ----------------------------------------------------------------------------
module piar_ctrl #(
  parameter int MAX_ENTRIES = piar_pkg::MAX_ENTRIES,
  parameter int DATA_WIDTH  = piar_pkg::DATA_WIDTH
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_stall_o,
  input  piar_pkg::in_item_t                           in_item_i,
  output logic                                         out_valid_o,
  input  logic                                         out_stall_i,
  output piar_pkg::out_item_t                          out_item_o,
  input  logic                                         cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  logic [piar_pkg::CNT_W-1:0]                   cfg_data_i,
  input  logic [MAX_ENTRIES-1:0][DATA_WIDTH-1:0]       cells_i,
  output piar_pkg::cmd_t                               cmd_o,
  output logic [(($clog2(MAX_ENTRIES+1) > 6) ?
                 $clog2(MAX_ENTRIES+1) : 6)-1:0]       pos_o,
  output logic [DATA_WIDTH-1:0]                        data_o,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]             count_o
);

  localparam int CntW      = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW      = (CntW > 6) ? CntW : 6;
  localparam int AddrW     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int GrowSteps = CntW + 1;
  localparam int OutCntW   = piar_pkg::CNT_W;
  localparam int OutValW   = piar_pkg::VAL_W;
  localparam int CapInit   = (piar_pkg::CAP_AT_RESET > MAX_ENTRIES) ?
                             MAX_ENTRIES : piar_pkg::CAP_AT_RESET;

  localparam logic [CmpW-1:0] MaxCmp   = CmpW'(MAX_ENTRIES);
  localparam logic [CntW-1:0] MaxCnt   = CntW'(MAX_ENTRIES);
  localparam logic [CntW-1:0] HalfCnt  = CntW'(MAX_ENTRIES / 2);
  localparam logic [CntW-1:0] CapReset = CntW'(CapInit);

  // raise capacity by doubling plus one until it covers want or reaches MAX_ENTRIES
  function automatic logic [CntW-1:0] grow(input logic [CntW-1:0] cap,
                                           input logic [CmpW-1:0] want);
    logic [CntW-1:0] c;
    c = cap;
    for (int k = 0; k < GrowSteps; k++) begin
      if (CmpW'(c) < want) begin
        if (c < HalfCnt) begin
          c = (c << 1) | CntW'(1);
        end else begin
          c = MaxCnt;
        end
      end
    end
    return c;
  endfunction

  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       cap_q, cap_d;
  logic                  out_valid_q;
  piar_pkg::out_item_t   out_q, res;
  piar_pkg::cmd_t        cmd;
  logic                  accept;
  logic                  ok;
  logic [DATA_WIDTH-1:0] rd;
  logic [CmpW-1:0]       pos_x, used_x, req_x, ins_pos, ins_next;
  logic [CntW-1:0]       cfg_cap;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign pos_x   = CmpW'(in_item_i.position);
  assign used_x  = CmpW'(count_q);
  assign req_x   = CmpW'(in_item_i.requested_capacity);
  assign ins_pos = (piar_pkg::op_e'(in_item_i.operation) == piar_pkg::OP_APPEND) ?
                   used_x : pos_x;
  assign ins_next = (ins_pos > used_x) ? (ins_pos + CmpW'(1)) : (used_x + CmpW'(1));

  assign cfg_cap = (CmpW'(cfg_data_i) > MaxCmp) ? MaxCnt : CntW'(cfg_data_i);

  always_comb begin
    ok      = 1'b0;
    rd      = '0;
    count_d = count_q;
    cap_d   = cap_q;
    cmd     = '0;
    pos_o   = pos_x;
    case (piar_pkg::op_e'(in_item_i.operation))
      piar_pkg::OP_READ: begin
        if (pos_x < MaxCmp) begin
          ok = 1'b1;
          rd = cells_i[pos_x[AddrW-1:0]];
        end
      end
      piar_pkg::OP_INSERT, piar_pkg::OP_APPEND: begin
        pos_o = ins_pos;
        if (ins_next <= MaxCmp) begin
          ok           = 1'b1;
          count_d      = ins_next[CntW-1:0];
          cap_d        = grow(cap_q, ins_next);
          cmd.write    = 1'b1;
          cmd.shift_up = (ins_pos < used_x);
        end
      end
      piar_pkg::OP_REMOVE: begin
        if (pos_x < used_x) begin
          ok             = 1'b1;
          count_d        = count_q - CntW'(1);
          cmd.shift_down = 1'b1;
        end
      end
      piar_pkg::OP_RESERVE: begin
        if (req_x <= MaxCmp) begin
          ok    = 1'b1;
          cap_d = grow(cap_q, req_x);
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  assign res.ok               = ok;
  assign res.read_value       = OutValW'(rd);
  assign res.entry_count      = OutCntW'(count_d);
  assign res.current_capacity = OutCntW'(cap_d);

  assign cmd_o   = accept ? cmd : '0;
  assign data_o  = DATA_WIDTH'(in_item_i.new_value);
  assign count_o = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        count_q <= '0;
        cap_q   <= cfg_cap;
      end else if (accept) begin
        count_q <= count_d;
        cap_q   <= cap_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= MaxCnt) && (cap_q <= MaxCnt))
    else $error("count or capacity beyond bound");

  a_refused_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ok && !cfg_valid_i) |=> (count_q == $past(count_q)))
    else $error("refused item changed the count");

  a_refused_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ok || !accept) |-> (cmd_o == '0))
    else $error("cell command without a successful item");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_valid_q && (out_q.entry_count == OutCntW'(count_q))))
    else $error("result missing or count mismatch");

endmodule

/* rtl/positional_insert_remove_array.sv */
// ----------------------------------------------------------------------------
// positional_insert_remove_array
// Bounded array with read, insert, append, remove and reserve at a position.
// ----------------------------------------------------------------------------
// Each item is one operation and yields exactly one result item, registered
// and shown on the cycle after the item is taken. An item is taken in every
// clock cycle in which the result register is free or being emptied, so the
// block runs at one item per clock; the row of cells shifts all entries in
// that single cycle, and the result waits in the result register. All cells clear
// at reset, with no sweep. A write of the capacity register reloads the
// capacity and empties the array but keeps cell contents.
module positional_insert_remove_array #(
  parameter int MAX_ENTRIES = piar_pkg::MAX_ENTRIES,
  parameter int DATA_WIDTH  = piar_pkg::DATA_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  piar_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output piar_pkg::out_item_t          out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [piar_pkg::CNT_W-1:0]   cfg_data_i
);

  localparam int CntW = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW = (CntW > 6) ? CntW : 6;

  logic [MAX_ENTRIES-1:0][DATA_WIDTH-1:0] cells;
  piar_pkg::cmd_t                         cmd;
  logic [CmpW-1:0]                        pos;
  logic [DATA_WIDTH-1:0]                  data;
  logic [CntW-1:0]                        count;

  piar_ctrl #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cells_i    (cells),
    .cmd_o      (cmd),
    .pos_o      (pos),
    .data_o     (data),
    .count_o    (count)
  );

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower, upper;

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cells[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cells[i+1];
    end

    piar_cell #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .pos_i  (pos),
      .count_i(count),
      .data_i (data),
      .lower_i(lower),
      .upper_i(upper),
      .q_o    (cells[i])
    );
  end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the positional insert/remove array. A short table of
// directed operations (typed results where obvious) is followed by random
// operations over several capacity settings and idling patterns. Every result
// item is compared field by field against its typed result or a shadow copy.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ENTRIES  = piar_pkg::MAX_ENTRIES;
  localparam int CAP_AT_RESET = piar_pkg::CAP_AT_RESET;
  localparam int OP_W         = piar_pkg::OP_W;
  localparam int POS_W        = piar_pkg::POS_W;
  localparam int VAL_W        = piar_pkg::VAL_W;
  localparam int CNT_W        = piar_pkg::CNT_W;

  localparam logic [OP_W-1:0] OP_UNKNOWN_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNKNOWN_HI = 3'd7;
  localparam int ITEMS_PER_PHASE = 315;
  localparam int NUM_PHASES      = 6;
  localparam int HOLD_CYCLES     = 250;
  localparam int MAX_PRINTED     = 50;

  typedef piar_pkg::in_item_t  in_item_t;
  typedef piar_pkg::out_item_t out_item_t;

  typedef struct packed {
    in_item_t  stim;
    logic      fixed;
    out_item_t want;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall_o;
  in_item_t         in_item = '0;
  logic             out_valid_o;
  logic             out_stall = 1'b0;
  out_item_t        out_item_o;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready_o;
  logic [CNT_W-1:0] cfg_data = '0;

  logic [VAL_W-1:0] shadow_cells [MAX_ENTRIES];
  int unsigned      shadow_count;
  int unsigned      shadow_cap;

  out_item_t   pending_results [$];
  row_t        dir_rows [$];
  out_item_t   due;
  int          errors = 0;
  int          result_no = 0;
  int          phase_no = 0;
  int          tx_idle_pct = 6;
  int          rx_idle_pct = 53;
  logic        hold_rx = 1'b0;

  positional_insert_remove_array u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb failed");
    $finish;
  end

  function automatic bit grow_cap(int unsigned want);
    if (want > MAX_ENTRIES) return 1'b0;
    while (shadow_cap < want) begin
      if (shadow_cap < MAX_ENTRIES / 2) begin
        shadow_cap = shadow_cap * 2 + 1;
      end else begin
        shadow_cap = MAX_ENTRIES;
        break;
      end
    end
    return 1'b1;
  endfunction

  function automatic bit put_cell(int unsigned pos, logic [VAL_W-1:0] val);
    int unsigned next_count;
    int unsigned i;
    next_count = (pos > shadow_count) ? pos + 1 : shadow_count + 1;
    if (!grow_cap(next_count)) return 1'b0;
    for (i = shadow_count; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
    shadow_cells[pos] = val;
    shadow_count = next_count;
    return 1'b1;
  endfunction

  function automatic bit take_cell(int unsigned pos);
    int unsigned i;
    if (pos >= shadow_count) return 1'b0;
    for (i = pos + 1; i < shadow_count; i++) shadow_cells[i-1] = shadow_cells[i];
    shadow_count--;
    return 1'b1;
  endfunction

  function automatic out_item_t next_array_result(in_item_t it);
    out_item_t r;
    int unsigned pos;
    pos = it.position;
    r = '0;
    case (it.operation)
      piar_pkg::OP_READ: begin
        if (pos < MAX_ENTRIES) begin
          r.ok = 1'b1;
          r.read_value = shadow_cells[pos];
        end
      end
      piar_pkg::OP_INSERT:  r.ok = put_cell(pos, it.new_value);
      piar_pkg::OP_APPEND:  r.ok = put_cell(shadow_count, it.new_value);
      piar_pkg::OP_REMOVE:  r.ok = take_cell(pos);
      piar_pkg::OP_RESERVE: r.ok = grow_cap(it.requested_capacity);
      default:              r.ok = 1'b0;
    endcase
    r.entry_count = shadow_count[CNT_W-1:0];
    r.current_capacity = shadow_cap[CNT_W-1:0];
    return r;
  endfunction

  function automatic in_item_t random_op();
    in_item_t it;
    int unsigned pick;
    it.new_value = VAL_W'($urandom);
    it.requested_capacity = CNT_W'($urandom);
    it.position = POS_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 18) begin
      it.operation = piar_pkg::OP_APPEND;
    end else if (pick < 36) begin
      it.operation = piar_pkg::OP_INSERT;
      if ($urandom_range(0, 3) != 0) it.position = POS_W'($urandom_range(0, shadow_count));
      else it.position = POS_W'($urandom_range(0, MAX_ENTRIES - 1));
    end else if (pick < 62) begin
      it.operation = piar_pkg::OP_REMOVE;
      if (shadow_count > 0 && $urandom_range(0, 7) != 0)
        it.position = POS_W'($urandom_range(0, shadow_count - 1));
    end else if (pick < 80) begin
      it.operation = piar_pkg::OP_READ;
      if ($urandom_range(0, 7) != 0) it.position = POS_W'($urandom_range(0, MAX_ENTRIES - 1));
    end else if (pick < 90) begin
      it.operation = piar_pkg::OP_RESERVE;
      if ($urandom_range(0, 3) != 0)
        it.requested_capacity = CNT_W'($urandom_range(0, MAX_ENTRIES));
    end else begin
      it.operation = OP_W'($urandom);
    end
    return it;
  endfunction

  task automatic add_row(input logic [OP_W-1:0] op, input int pos, input int val,
                         input int req, input bit fixed, input int ok, input int rd,
                         input int cnt, input int cap);
    row_t r;
    r.stim.operation = op;
    r.stim.position = POS_W'(pos);
    r.stim.new_value = VAL_W'(val);
    r.stim.requested_capacity = CNT_W'(req);
    r.fixed = fixed;
    r.want.ok = 1'(ok);
    r.want.read_value = VAL_W'(rd);
    r.want.entry_count = CNT_W'(cnt);
    r.want.current_capacity = CNT_W'(cap);
    dir_rows.push_back(r);
  endtask

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    errors++;
    if (errors <= MAX_PRINTED)
      $display("mismatch at result %0d: %s got %0h expected %0h", result_no, what, got, want);
  endtask

  task automatic send_op(input in_item_t it, input bit fixed, input out_item_t typed);
    out_item_t predicted;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    predicted = next_array_result(it);
    pending_results.push_back(fixed ? typed : predicted);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    cfg_valid <= 1'b0;
    shadow_cap = (v > MAX_ENTRIES) ? MAX_ENTRIES : v;
    shadow_count = 0;
  endtask

  always @(posedge clk) begin
    out_stall <= hold_rx || ($urandom_range(0, 99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result with nothing pending", out_item_o, 0);
      end else begin
        due = pending_results.pop_front();
        if (out_item_o.ok !== due.ok) flag_mismatch("ok", out_item_o.ok, due.ok);
        if (out_item_o.read_value !== due.read_value)
          flag_mismatch("read_value", out_item_o.read_value, due.read_value);
        if (out_item_o.entry_count !== due.entry_count)
          flag_mismatch("entry_count", out_item_o.entry_count, due.entry_count);
        if (out_item_o.current_capacity !== due.current_capacity)
          flag_mismatch("current_capacity", out_item_o.current_capacity,
                        due.current_capacity);
      end
      result_no++;
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    wait (phase_no == 4);
    repeat (20) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    int ph;
    logic [CNT_W-1:0] cap_setting;
    foreach (shadow_cells[i]) shadow_cells[i] = '0;
    shadow_count = 0;
    shadow_cap = CAP_AT_RESET;

    add_row(piar_pkg::OP_READ,     0,    0,  0, 1, 1, 0, 0, CAP_AT_RESET);
    add_row(piar_pkg::OP_READ,    31,    0,  0, 1, 0, 0, 0, CAP_AT_RESET);
    add_row(piar_pkg::OP_REMOVE,   0,    0,  0, 1, 0, 0, 0, CAP_AT_RESET);
    add_row(OP_UNKNOWN_LO,         0,    0,  0, 1, 0, 0, 0, CAP_AT_RESET);
    add_row(OP_UNKNOWN_HI,        31,  255, 31, 1, 0, 0, 0, CAP_AT_RESET);
    add_row(piar_pkg::OP_RESERVE,  0,    0, 31, 1, 0, 0, 0, CAP_AT_RESET);
    add_row(piar_pkg::OP_RESERVE,  0,    0,  0, 1, 1, 0, 0, CAP_AT_RESET);
    add_row(piar_pkg::OP_APPEND,   0,  255,  0, 1, 1, 0, 1, CAP_AT_RESET);
    add_row(piar_pkg::OP_INSERT,   0,    0,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_INSERT,  12, 'ha5,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_READ,     5,    0,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_READ,    12,    0,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_INSERT,  16, 'h5a,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_INSERT,  31,  255,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_APPEND,   0, 'h11,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_APPEND,   0, 'h22,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_APPEND,   0, 'h33,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_APPEND,   0, 'h44,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_INSERT,   3, 'h66,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_READ,    15,    0,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_REMOVE,  15,    0,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_REMOVE,   0,    0,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_REMOVE,  31,    0,  0, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_RESERVE,  0,    0, 16, 0, 0, 0, 0, 0);
    add_row(piar_pkg::OP_READ,    16,    0,  0, 0, 0, 0, 0, 0);
    add_row(OP_UNKNOWN_LO + 3'd1,  7,    0,  9, 0, 0, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_op(dir_rows[i].stim, dir_rows[i].fixed, dir_rows[i].want);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        in_valid <= 1'b0;
        case (ph)
          1: cap_setting = '0;
          2: cap_setting = CNT_W'(31);
          3: cap_setting = CNT_W'(MAX_ENTRIES);
          4: cap_setting = CNT_W'(7);
          default: cap_setting = CNT_W'($urandom_range(1, MAX_ENTRIES - 1));
        endcase
        write_capacity(cap_setting);
      end
      if (ph < 2) begin
        tx_idle_pct = 6;
        rx_idle_pct = 53;
      end else if (ph < 4) begin
        tx_idle_pct = 53;
        rx_idle_pct = 6;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      phase_no = ph;
      repeat (ITEMS_PER_PHASE) send_op(random_op(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

/* positional_insert_remove_array.f */
rtl/piar_pkg.sv
rtl/piar_cell.sv
rtl/piar_ctrl.sv
rtl/positional_insert_remove_array.sv
tb/sv/tb.sv
